FILE: sv/thmp_pkg.sv
// ----------------------------------------------------------------------------
// thmp_pkg: shared types and constants of the handshake message parser
// Message codes, byte roles, error codes, register indexes and the state,
// configuration and result structures passed between the parser modules.
// ----------------------------------------------------------------------------
package thmp_pkg;

   // handshake message types
   localparam logic [7:0] MSG_SERVER_HELLO = 8'd2;
   localparam logic [7:0] MSG_SERVER_KEX   = 8'd12;
   localparam logic [7:0] MSG_HELLO_DONE   = 8'd14;

   // field layout and expected values
   localparam logic [7:0]  SH_RANDOM_START = 8'd2;
   localparam logic [7:0]  SH_SID_LEN_POS  = 8'd34;
   localparam logic [8:0]  SH_SUITE_BASE   = 9'd35;
   localparam logic [8:0]  SH_MIN_BASE     = 9'd36;
   localparam logic [7:0]  KEX_CURVE_TYPE  = 8'd3;
   localparam logic [7:0]  KEX_KEY_LEN     = 8'd32;
   localparam logic [7:0]  KEX_KEY_START   = 8'd4;
   localparam logic [7:0]  KEX_KEY_END     = 8'd36;
   localparam logic [7:0]  KEX_MIN_LEN     = 8'd35;

   // register reset values
   localparam logic [15:0] SUITE_A_RESET = 16'hc02f;
   localparam logic [15:0] SUITE_B_RESET = 16'hc02b;
   localparam logic [15:0] CURVE_RESET   = 16'h001d;

   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUITE_A = 2'd0,
      CSR_SUITE_B = 2'd1,
      CSR_CURVE   = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ROLE_HEADER  = 3'd0,
      ROLE_BODY    = 3'd1,
      ROLE_RANDOM  = 3'd2,
      ROLE_KEY     = 3'd3,
      ROLE_IGNORED = 3'd4
   } role_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_SUITE  = 3'd1,
      ERR_CURVE_TYPE = 3'd2,
      ERR_CURVE_ID   = 3'd3,
      ERR_KEY_LEN    = 3'd4,
      ERR_TRUNCATED  = 3'd5
   } err_type;

   localparam logic [2:0] HDR_BODY = 3'd4;

   typedef struct packed {
      logic [2:0]  header_pos;
      logic [7:0]  cur_type;
      logic [23:0] body_length;
      logic [23:0] body_pos;
      logic [7:0]  session_id_len;
      logic [7:0]  partial_word;
      logic        done_flag;
      err_type     error_reg;
   } state_type;

   typedef struct packed {
      logic [15:0] accepted_suite_a;
      logic [15:0] accepted_suite_b;
      logic [15:0] required_curve;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  msg_type;
      role_type    byte_role;
      logic [4:0]  field_index;
      logic [7:0]  value;
      logic        msg_last;
      logic        suite_checked;
      logic [15:0] cipher_suite;
      logic        hello_done;
      err_type     error_code;
   } result_type;

endpackage

FILE: sv/thmp_if.sv
// ----------------------------------------------------------------------------
// thmp_if: channel interfaces of the handshake message parser
// Byte input channel, result channel and register write channel, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface thmp_req_if;
   import thmp_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface thmp_rsp_if;
   import thmp_pkg::*;
   logic        valid;
   logic        ready;
   logic [7:0]  msg_type;
   role_type    byte_role;
   logic [4:0]  field_index;
   logic [7:0]  value;
   logic        msg_last;
   logic        suite_checked;
   logic [15:0] cipher_suite;
   logic        hello_done;
   err_type     error_code;
   modport source (output valid, output msg_type, output byte_role, output field_index,
                   output value, output msg_last, output suite_checked,
                   output cipher_suite, output hello_done, output error_code,
                   input ready);
   modport sink   (input valid, input msg_type, input byte_role, input field_index,
                   input value, input msg_last, input suite_checked,
                   input cipher_suite, input hello_done, input error_code,
                   output ready);
endinterface

interface thmp_csr_if;
   import thmp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [15:0]          data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/tls_handshake_message_parser_top.sv
// ----------------------------------------------------------------------------
// tls_handshake_message_parser_top: TLS 1.2 handshake message parser
// Splits a handshake byte stream into messages, tags server random and key
// bytes, checks cipher suite and curve, flags truncation and raises done.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+-----------
//   req_ch   | in  | data_byte                                 | valid/ready
//   rsp_ch   | out | msg_type .. error_code, one per byte      | valid/ready
//   csr_ch   | in  | index (0 suite a, 1 suite b, 2 curve)     | valid/ready
//
// One byte per cycle sustained while rsp_ch is ready; a byte is held in the input
// register, then passes through the single parse step into the result register.
// Synchronous active-high reset clears parser state and loads register defaults.
// A stalled result holds both stages; the input stage still takes a byte while
// it is empty. csr_ch is always ready.
// ----------------------------------------------------------------------------
module tls_handshake_message_parser_top (
   input  logic            clock,
   input  logic            reset,
   thmp_req_if.sink        req_ch,
   thmp_rsp_if.source      rsp_ch,
   thmp_csr_if.sink        csr_ch
);
   import thmp_pkg::*;

   // configuration registers
   cfg_type    cfg_ff;
   cfg_type    cfg_in;

   // parser state
   state_type  state_ff;
   state_type  state_in;

   // input stage
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;

   // result stage
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type step_res;
   state_type  step_state;

   logic       advance;
   logic       req_xfer;

   // move a byte from input to result stage when the result slot is free
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_xfer = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   thmp_parse u_parse (
      .st        (state_ff),
      .cfg       (cfg_ff),
      .data_byte (in_byte_ff),
      .nst       (step_state),
      .res       (step_res)
   );

   // register writes: drop indexes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_idx_type'(csr_ch.index))
            CSR_SUITE_A: cfg_in.accepted_suite_a = csr_ch.data;
            CSR_SUITE_B: cfg_in.accepted_suite_b = csr_ch.data;
            CSR_CURVE:   cfg_in.required_curve   = csr_ch.data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   // advance the state only when a byte is actually parsed
   assign state_in     = advance ? step_state : state_ff;
   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accepted_suite_a <= SUITE_A_RESET;
         cfg_ff.accepted_suite_b <= SUITE_B_RESET;
         cfg_ff.required_curve   <= CURVE_RESET;
         state_ff                <= '0;
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_ch.data_byte;
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.msg_type      = out_ff.msg_type;
   assign rsp_ch.byte_role     = out_ff.byte_role;
   assign rsp_ch.field_index   = out_ff.field_index;
   assign rsp_ch.value         = out_ff.value;
   assign rsp_ch.msg_last      = out_ff.msg_last;
   assign rsp_ch.suite_checked = out_ff.suite_checked;
   assign rsp_ch.cipher_suite  = out_ff.cipher_suite;
   assign rsp_ch.hello_done    = out_ff.hello_done;
   assign rsp_ch.error_code    = out_ff.error_code;

`ifndef SYNTH
   // an error, once raised, never changes
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff.error_reg != ERR_NONE) |=> (state_ff.error_reg == $past(state_ff.error_reg)))
      else $error("error code changed after being set");

   // the header counter never passes the body marker
   a_header_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.header_pos <= HDR_BODY))
      else $error("header position out of range");

   // a full, stalled input stage never takes another byte
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_xfer)
      else $error("input stage overrun");

   // a suite report only comes from a ServerHello
   a_suite_in_hello: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.suite_checked) |-> (out_ff.msg_type == MSG_SERVER_HELLO))
      else $error("suite check outside ServerHello");
`endif

endmodule

FILE: sv/thmp_parse.sv
// ----------------------------------------------------------------------------
// thmp_parse: per-byte parsing step
// From the current parser state, the configuration and one stream byte,
// forms the next state and the result of that byte.
// ----------------------------------------------------------------------------
module thmp_parse (
   input  thmp_pkg::state_type  st,
   input  thmp_pkg::cfg_type    cfg,
   input  logic [7:0]           data_byte,
   output thmp_pkg::state_type  nst,
   output thmp_pkg::result_type res
);
   import thmp_pkg::*;

   logic [23:0] p;
   logic        last;
   logic [8:0]  suite_off;
   logic [8:0]  min_len;
   logic [15:0] word;

   assign p         = st.body_pos;
   assign last      = ({1'b0, p} + 25'd1) == {1'b0, st.body_length};
   assign suite_off = SH_SUITE_BASE + {1'b0, st.session_id_len};
   assign word      = {st.partial_word, data_byte};

   always_comb begin
      nst     = st;
      res     = '0;
      res.byte_role  = ROLE_IGNORED;
      res.error_code = ERR_NONE;
      res.value      = data_byte;
      min_len        = SH_MIN_BASE;

      if (!st.done_flag && st.error_reg == ERR_NONE) begin
         if (st.header_pos != HDR_BODY) begin
            res.byte_role = ROLE_HEADER;
            if (st.header_pos == 3'd0) begin
               nst.cur_type    = data_byte;
               nst.body_length = '0;
            end else begin
               nst.body_length = {st.body_length[15:0], data_byte};
            end
            res.msg_type   = nst.cur_type;
            nst.header_pos = st.header_pos + 3'd1;
            if (st.header_pos == 3'd3) begin
               nst.body_pos = '0;
               if (nst.body_length == 24'd0) begin
                  // empty body: message ends on its last header byte
                  res.msg_last   = 1'b1;
                  nst.header_pos = 3'd0;
                  if (nst.cur_type == MSG_SERVER_HELLO || nst.cur_type == MSG_SERVER_KEX) begin
                     nst.error_reg = ERR_TRUNCATED;
                  end else if (nst.cur_type == MSG_HELLO_DONE) begin
                     nst.done_flag = 1'b1;
                  end
               end
            end
         end else begin
            res.msg_type  = st.cur_type;
            res.byte_role = ROLE_BODY;
            res.msg_last  = last;
            case (st.cur_type)
               MSG_SERVER_HELLO: begin
                  if (p >= {16'd0, SH_RANDOM_START} && p < {16'd0, SH_SID_LEN_POS}) begin
                     res.byte_role   = ROLE_RANDOM;
                     res.field_index = p[4:0] - SH_RANDOM_START[4:0];
                  end else if (p == {16'd0, SH_SID_LEN_POS}) begin
                     nst.session_id_len = data_byte;
                  end else if (p == {15'd0, suite_off}) begin
                     nst.partial_word = data_byte;
                  end else if (p == {15'd0, suite_off} + 24'd1) begin
                     res.cipher_suite  = word;
                     res.suite_checked = 1'b1;
                     if (word != cfg.accepted_suite_a && word != cfg.accepted_suite_b) begin
                        nst.error_reg = ERR_BAD_SUITE;
                     end
                  end
                  // the session id length may have been taken on this very byte
                  min_len = SH_MIN_BASE + {1'b0, nst.session_id_len};
                  if (last && p < {15'd0, min_len} && nst.error_reg == ERR_NONE) begin
                     nst.error_reg = ERR_TRUNCATED;
                  end
               end
               MSG_SERVER_KEX: begin
                  if (p == 24'd0) begin
                     if (data_byte != KEX_CURVE_TYPE) nst.error_reg = ERR_CURVE_TYPE;
                  end else if (p == 24'd1) begin
                     nst.partial_word = data_byte;
                  end else if (p == 24'd2) begin
                     if (word != cfg.required_curve) nst.error_reg = ERR_CURVE_ID;
                  end else if (p == 24'd3) begin
                     if (data_byte != KEX_KEY_LEN) nst.error_reg = ERR_KEY_LEN;
                  end else if (p < {16'd0, KEX_KEY_END}) begin
                     res.byte_role   = ROLE_KEY;
                     res.field_index = p[4:0] - KEX_KEY_START[4:0];
                  end
                  if (last && p < {16'd0, KEX_MIN_LEN} && nst.error_reg == ERR_NONE) begin
                     nst.error_reg = ERR_TRUNCATED;
                  end
               end
               MSG_HELLO_DONE: begin
                  if (last) nst.done_flag = 1'b1;
               end
               default: begin
               end
            endcase
            nst.body_pos = p + 24'd1;
            if (last) nst.header_pos = 3'd0;
         end
      end

      res.hello_done = nst.done_flag;
      res.error_code = nst.error_reg;
   end

endmodule
